@@ rtl/core/saffp_pkg.sv @@
// saffp_pkg: shared types, constants and the sequencer program of the
// square atlas first-fit placer. No dependencies.
package saffp_pkg;

  localparam int MAX_ATLAS_LOG2_DEF = 6;
  localparam int TILE_W = 3;
  localparam int CFG_W = 3;
  localparam int POS_W = 6;
  localparam logic [CFG_W-1:0] ATLAS_RESET = 3'd6;

  // register index as taken from paddr[2]
  localparam logic REG_ATLAS_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_PAST_EDGE = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MARK,
    S_DONE
  } step_t;

  typedef enum logic [2:0] {
    C_IN_ACC,
    C_SCAN_END,
    C_NOT_PLACE,
    C_MARK_END,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  scan;
    logic  decide;
    logic  mark;
    logic  emit;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctl_t;

  // control store: one word per step
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w = '{in_rdy: 1'b0, scan: 1'b0, decide: 1'b0, mark: 1'b0, emit: 1'b0,
          cond: C_IN_ACC, t_true: S_IDLE, t_false: S_IDLE};
    unique case (s)
      S_IDLE: begin
        w.in_rdy = 1'b1; w.cond = C_IN_ACC; w.t_true = S_SCAN; w.t_false = S_IDLE;
      end
      S_SCAN: begin
        w.scan = 1'b1; w.cond = C_SCAN_END; w.t_true = S_DECIDE; w.t_false = S_SCAN;
      end
      S_DECIDE: begin
        w.decide = 1'b1; w.cond = C_NOT_PLACE; w.t_true = S_DONE; w.t_false = S_MARK;
      end
      S_MARK: begin
        w.mark = 1'b1; w.cond = C_MARK_END; w.t_true = S_DONE; w.t_false = S_MARK;
      end
      S_DONE: begin
        w.emit = 1'b1; w.cond = C_OUT_FREE; w.t_true = S_IDLE; w.t_false = S_DONE;
      end
      default: begin
        w.cond = C_IN_ACC; w.t_true = S_IDLE; w.t_false = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/square_atlas_first_fit_placer.sv @@
// square_atlas_first_fit_placer: microcoded first-fit placer of square tiles
// over a row-wide occupancy memory. Depends on saffp_pkg.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata: tile_size_log2; tuser: clear_first
//  out_    | out | tvalid/tready      | tdata: x_pos, y_pos; tuser: status
//  cfg_    | in  | apb, pready high   | reg 0 at 0x0: atlas_size_log2
//
// an item goes through the idle, scan, decide, mark and done steps, the mark step
// only for a placed tile, whose found row plus tile rows never exceed the edge; the
// done step may wait for out_tready. the scan and the read-modify-write marking
// each go through the single-row memory port at one row a cycle. reset (rst_n,
// synchronous) clears the per-row valid bits at once, so no clearing pass is
// needed; clear_first does the same in the accept cycle. a waiting result sits in
// the output register while the next word is taken in.
module square_atlas_first_fit_placer #(
  parameter int MAX_ATLAS_LOG2 = saffp_pkg::MAX_ATLAS_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] tile_size_log2, rest zero
  input  logic [0:0]  in_tuser,   // [0] clear_first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] x_pos, [11:6] y_pos, rest zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import saffp_pkg::*;

  localparam int L     = MAX_ATLAS_LOG2;
  localparam int EDGE  = 1 << L;
  localparam int RW    = L + 1;
  localparam int LW    = $clog2(MAX_ATLAS_LOG2 + 1);
  localparam int SUM_W = ((L > 7) ? L : 7) + 1;

  function automatic logic [EDGE-1:0] lowmask(input logic [SUM_W-1:0] n);
    logic [EDGE-1:0] m;
    for (int i = 0; i < EDGE; i++) m[i] = (SUM_W'(i) < n);
    return m;
  endfunction

  function automatic logic [L-1:0] encode(input logic [EDGE-1:0] oh);
    logic [L-1:0] idx;
    idx = '0;
    for (int i = 0; i < EDGE; i++) if (oh[i]) idx = idx | L'(i);
    return idx;
  endfunction

  // configuration
  logic [CFG_W-1:0] atlas_r;
  logic             cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ATLAS_SIZE) ? 32'(atlas_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_r <= ATLAS_RESET;
    end else if (cfg_we && cfg_paddr[2] == REG_ATLAS_SIZE) begin
      atlas_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  logic [LW-1:0] eff_c;
  logic [RW-1:0] edge_c;

  always_comb begin
    if (atlas_r == '0) begin
      eff_c = LW'(1);
    end else if (int'(atlas_r) > MAX_ATLAS_LOG2) begin
      eff_c = LW'(MAX_ATLAS_LOG2);
    end else begin
      eff_c = LW'(atlas_r);
    end
    edge_c = RW'(1) << eff_c;
  end

  // sequencer
  step_t step_r, step_nxt;
  ctl_t  cw;
  logic  cond_c;

  // datapath registers
  logic [TILE_W-1:0] tile_r;
  logic [RW-1:0]     row_r;
  logic              pend_r;
  logic              found_r;
  logic [L-1:0]      x_r, y_r;
  logic [RW-1:0]     end_r;
  logic [EDGE-1:0]   mask_r;
  status_t           status_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  out_x_r, out_y_r;
  status_t           out_status_r;

  // occupancy memory and per-row valid bits
  logic [EDGE-1:0] mem [EDGE];
  logic [EDGE-1:0] row_vld_r;
  logic [EDGE-1:0] rdata_r;
  logic            rvalid_r;
  logic            mem_we;
  logic [L-1:0]    raddr, waddr;
  logic [EDGE-1:0] wdata;

  logic            in_acc;
  logic [EDGE-1:0] rdata_eff, free_c, onehot_c;
  logic            row_free_c;
  logic            scan_found_c, scan_exh_c;
  logic [SUM_W-1:0] tile_c, x_end_c, y_end_c;
  logic            placed_c;
  logic            out_free_c;

  assign cw        = ucode(step_r);
  assign in_tready = cw.in_rdy;
  assign in_acc    = in_tvalid & in_tready;

  assign rdata_eff  = rvalid_r ? rdata_r : '0;
  assign free_c     = ~rdata_eff & lowmask(SUM_W'(edge_c));
  assign onehot_c   = free_c & (~free_c + 1'b1);
  assign row_free_c = |free_c;

  assign scan_found_c = pend_r & row_free_c;
  assign scan_exh_c   = pend_r & ~row_free_c & (row_r == edge_c);

  assign tile_c   = SUM_W'(1) << tile_r;
  assign x_end_c  = SUM_W'(x_r) + tile_c;
  assign y_end_c  = SUM_W'(y_r) + tile_c;
  assign placed_c = found_r && (x_end_c <= SUM_W'(edge_c)) && (y_end_c <= SUM_W'(edge_c));

  assign out_free_c = ~out_valid_r | out_tready;

  assign raddr  = row_r[L-1:0];
  assign waddr  = L'(row_r - RW'(1));
  assign wdata  = rdata_eff | mask_r;
  assign mem_we = cw.mark & pend_r;

  always_comb begin
    unique case (cw.cond)
      C_IN_ACC:    cond_c = in_acc;
      C_SCAN_END:  cond_c = scan_found_c | scan_exh_c;
      C_NOT_PLACE: cond_c = ~placed_c;
      C_MARK_END:  cond_c = pend_r & (row_r == end_r);
      C_OUT_FREE:  cond_c = out_free_c;
      default:     cond_c = 1'b0;
    endcase
    step_nxt = cond_c ? cw.t_true : cw.t_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rvalid_r  <= 1'b0;
    end else begin
      rvalid_r <= row_vld_r[raddr];
      if (in_acc && in_tuser[0]) begin
        row_vld_r <= '0;
      end else if (mem_we) begin
        row_vld_r[waddr] <= 1'b1;
      end
    end
  end

  // scan, decide and mark datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      row_r   <= '0;
    end else begin
      if (in_acc) begin
        tile_r <= in_tdata[TILE_W-1:0];
        row_r  <= '0;
        pend_r <= 1'b0;
      end
      if (cw.scan) begin
        row_r  <= row_r + RW'(1);
        pend_r <= 1'b1;
        if (scan_found_c) begin
          found_r <= 1'b1;
          x_r     <= encode(onehot_c);
          y_r     <= L'(row_r - RW'(1));
        end else if (scan_exh_c) begin
          found_r <= 1'b0;
        end
      end
      if (cw.decide) begin
        row_r  <= RW'(y_r);
        pend_r <= 1'b0;
        end_r  <= RW'(y_end_c);
        mask_r <= lowmask(x_end_c) & ~lowmask(SUM_W'(x_r));
        if (!found_r) begin
          status_r <= ST_NO_FREE;
        end else if (!placed_c) begin
          status_r <= ST_PAST_EDGE;
        end else begin
          status_r <= ST_PLACED;
        end
      end
      if (cw.mark) begin
        row_r  <= row_r + RW'(1);
        pend_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cw.emit && out_free_c) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_x_r      <= (status_r == ST_PLACED) ? POS_W'(x_r) : '0;
        out_y_r      <= (status_r == ST_PLACED) ? POS_W'(y_r) : '0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_y_r, out_x_r};
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_mark_in_atlas: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (RW'(waddr) < edge_c))
    else $error("mark write outside atlas");

  a_placed_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.mark && status_r == ST_PLACED) |-> (x_end_c <= SUM_W'(edge_c)))
    else $error("marking a tile that runs past the edge");

  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_PLACED) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("position not zero on failed placement");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (step_r == S_SCAN && !pend_r))
    else $error("accepted word did not start a scan");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the square atlas first-fit placer, with its own
// occupancy-mask predictor, directed and random tile streams and apb set-up.
// Depends on saffp_pkg and square_atlas_first_fit_placer.
`timescale 1ns / 1ps

module tb_top;
  import saffp_pkg::*;

  localparam int MAX_LOG2 = MAX_ATLAS_LOG2_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam logic [2:0] ATLAS_ADDR = {REG_ATLAS_SIZE, 2'b00};

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    status_t          status;
  } placement_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [2:0] tile_size_log2, rest zero
  logic [0:0]  in_tuser = '0;     // [0] clear_first
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [5:0] x_pos, [11:6] y_pos, rest zero
  logic [1:0]  out_tuser;         // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  square_atlas_first_fit_placer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state: the occupancy mask by (row, column) and the atlas register
  logic [63:0]      occ_rows [64];
  logic [CFG_W-1:0] atlas_reg;
  placement_t       pending_q [$];

  int errors = 0;
  int n_tiles = 0;
  int n_placed = 0;
  int n_no_free = 0;
  int n_past_edge = 0;
  int n_settings = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_reqs = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int atlas_log2();
    if (atlas_reg == 3'd0) return 1;
    if (int'(atlas_reg) > MAX_LOG2) return MAX_LOG2;
    return int'(atlas_reg);
  endfunction

  function automatic placement_t place_tile(input logic [2:0] tile_log2, input logic clr);
    placement_t res;
    int edge_len, tile_len, fx, fy;
    bit found;
    edge_len = 1 << atlas_log2();
    tile_len = 1 << tile_log2;
    found = 1'b0;
    fx = 0;
    fy = 0;
    if (clr) begin
      foreach (occ_rows[r]) occ_rows[r] = '0;
    end
    // raster scan for the first free cell
    for (int r = 0; r < edge_len && !found; r++) begin
      for (int c = 0; c < edge_len; c++) begin
        if (!found && !occ_rows[r][c]) begin
          fx = c;
          fy = r;
          found = 1'b1;
        end
      end
    end
    res = '{x: '0, y: '0, status: ST_PLACED};
    if (!found) begin
      res.status = ST_NO_FREE;
      n_no_free++;
    end else if (fx + tile_len > edge_len || fy + tile_len > edge_len) begin
      res.status = ST_PAST_EDGE;
      n_past_edge++;
    end else begin
      for (int r = fy; r < fy + tile_len; r++)
        for (int c = fx; c < fx + tile_len; c++)
          occ_rows[r][c] = 1'b1;
      res.x = fx[POS_W-1:0];
      res.y = fy[POS_W-1:0];
      n_placed++;
    end
    return res;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("tb_top: mismatch: %s", msg);
  endtask

  // result side: check every accepted word, then choose the next tready
  task automatic check_placement();
    placement_t want;
    logic [POS_W-1:0] got_x, got_y;
    logic [1:0] got_st;
    got_x = out_tdata[5:0];
    got_y = out_tdata[11:6];
    got_st = out_tuser;
    if (pending_q.size() == 0) begin
      note_error($sformatf("result x=%0d y=%0d status=%0d with no tile pending",
                           got_x, got_y, got_st));
      return;
    end
    want = pending_q.pop_front();
    if (got_x !== want.x || got_y !== want.y || got_st !== want.status)
      note_error($sformatf("expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                           want.x, want.y, want.status, got_x, got_y, got_st));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_placement();
    if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_seen <= rx_hold_reqs;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_TX:   begin tx_idle_pct = 65; rx_stall_pct = 0;  end
      IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 65; end
      default:   begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
    endcase
  endtask

  task automatic send_tile(input logic [2:0] tile_log2, input logic clr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, tile_log2};
    in_tuser <= clr;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(place_tile(tile_log2, clr));
    n_tiles++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // leaves psel high so that a following transfer starts without a gap
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic set_atlas(input logic [2:0] val);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, ATLAS_ADDR, {29'b0, val}, rd);
    apb_xfer(1'b0, ATLAS_ADDR, '0, rd);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    atlas_reg = val;
    n_settings++;
    if (rd[2:0] !== val)
      note_error($sformatf("atlas_size_log2 read back %0d, written %0d", rd[2:0], val));
  endtask

  task automatic test_directed();
    // whole atlas, then full, then a tile wider than the atlas
    send_tile(3'd6, 1'b1);
    send_tile(3'd0, 1'b0);
    send_tile(3'd7, 1'b1);
    // two halves across the top, then a full-size tile falls off the bottom
    send_tile(3'd5, 1'b1);
    send_tile(3'd5, 1'b0);
    send_tile(3'd6, 1'b0);
    // shrinking tiles along row 0 push x out to the last column
    send_tile(3'd5, 1'b1);
    for (int s = 4; s >= 0; s--) send_tile(3'(s), 1'b0);
    send_tile(3'd0, 1'b0);
    // zero saturates up to the smallest atlas
    set_atlas(3'd0);
    send_tile(3'd1, 1'b1);
    send_tile(3'd0, 1'b0);
    send_tile(3'd2, 1'b1);
    // seven saturates down to the largest
    set_atlas(3'd7);
    send_tile(3'd6, 1'b1);
    // mask kept across a size change
    set_atlas(3'd6);
    send_tile(3'd1, 1'b1);
    set_atlas(3'd1);
    send_tile(3'd0, 1'b0);
    set_atlas(3'd3);
    send_tile(3'd0, 1'b0);
    send_tile(3'd3, 1'b0);
    drain();
  endtask

  task automatic run_random_tiles(input int count);
    int sent, kind, len;
    logic [2:0] sz;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        // well-formed: clear, then largest first
        len = $urandom_range(24, 1);
        sz = 3'($urandom_range(atlas_log2()));
        for (int i = 0; i < len && sent < count; i++) begin
          send_tile(sz, i == 0);
          sent++;
          if (sz != 0 && $urandom_range(2) == 0) sz = sz - 3'($urandom_range(int'(sz), 1));
        end
      end else if (kind < 9) begin
        send_tile(3'($urandom_range(7)), $urandom_range(7) == 0);
        sent++;
      end else begin
        // broken order: sizes growing after a clear
        len = $urandom_range(6, 2);
        sz = 3'($urandom_range(2));
        for (int i = 0; i < len && sent < count; i++) begin
          send_tile(sz, i == 0);
          sent++;
          if (sz != 3'd7) sz = sz + 3'd1;
        end
      end
    end
  endtask

  task automatic test_random_phase(input idle_mode_t mode);
    set_idle(mode);
    for (int seg = 0; seg < 5; seg++) begin
      if ($urandom_range(9) == 0) set_atlas(3'($urandom_range(7)));
      else set_atlas(3'($urandom_range(6, 1)));
      run_random_tiles(55);
    end
    drain();
  endtask

  task automatic test_backpressure();
    set_idle(IDLE_NONE);
    set_atlas(3'd4);
    rx_hold_reqs++;
    // the block fills up and stalls its input while results are held off
    send_tile(3'd2, 1'b1);
    for (int i = 0; i < 15; i++) send_tile(3'($urandom_range(2)), 1'b0);
    drain();
    for (int i = 0; i < 8; i++) send_tile(3'($urandom_range(3)), i == 0);
    drain();
  endtask

  initial begin
    foreach (occ_rows[r]) occ_rows[r] = '0;
    atlas_reg = ATLAS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(IDLE_NONE);
    test_random_phase(IDLE_TX);
    test_random_phase(IDLE_RX);
    test_random_phase(IDLE_BOTH);
    test_backpressure();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb_top: %0d tiles over %0d atlas settings: %0d placed, %0d no free cell, %0d past edge",
             n_tiles, n_settings, n_placed, n_no_free, n_past_edge);
    $display("tb_top: idling none/sender/receiver/both, long result hold-off, %0d mismatches",
             errors);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
